// ----- src/button_press_classifier_unit_assert.svh -----
// Assertion macros used by the checker file.
`ifndef BUTTON_PRESS_CLASSIFIER_UNIT_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, skipped while reset is low.
`define BPC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("button classifier assertion failed");

// Next-cycle implication, skipped while reset is low.
`define BPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("button classifier assertion failed");

// Next-cycle implication that also holds across reset.
`define BPC_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("button classifier assertion failed");

`endif

// ----- src/bpc_pkg.sv -----
package bpc_pkg;

    // Press tracking phase
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_HELD     = 2'd1,
        PH_RELEASED = 2'd2
    } t_phase;

    // Event codes reported once per tick
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SCAN_PERIOD = 2'd0,
        CFG_ACTIVE_LVL  = 2'd1,
        CFG_DOUBLE_GAP  = 2'd2,
        CFG_LONG_PRESS  = 2'd3
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned TICK_W     = 16;
    localparam int unsigned PERIOD_W   = 8;

    // Reset values
    localparam logic [PERIOD_W-1:0] RST_SCAN_PERIOD = 8'd10;
    localparam logic                RST_ACTIVE_LVL  = 1'b0;
    localparam logic [TICK_W-1:0]   RST_DOUBLE_GAP  = 16'd100;
    localparam logic [TICK_W-1:0]   RST_LONG_PRESS  = 16'd500;
    localparam logic [TICK_W-1:0]   RST_LONG_TICKS  = 16'd50;
    localparam logic [TICK_W-1:0]   RST_GAP_TICKS   = 16'd10;

    // Settings handed from the threshold unit to the classifier core
    typedef struct packed {
        logic              busy;
        logic              active_level;
        logic [TICK_W-1:0] long_ticks;
        logic [TICK_W-1:0] gap_ticks;
    } t_thresh;

endpackage

// ----- src/button_press_classifier_unit.sv -----
// Channel   | Dir | Word / fields
// s_axis    | in  | tdata[0] pin_level, tdata[7:1] zero
// m_axis    | out | tdata[1:0] event_res, tdata[7:2] zero
// cfg       | in  | i_cfg_we, i_cfg_idx (register index), i_cfg_data
//
// One tick word per cycle while the divider is idle and no result stalls.
// A config write taken with no press in progress runs the threshold divider
// (a load step, then one quotient bit per cycle); s_axis_tready is low while
// it runs. Synchronous reset restores the reset config, the thresholds (50
// and 10 ticks) and the idle phase. A stalled result holds in the output
// register while the input register takes one more word.
module button_press_classifier_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [0] pin_level
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,  // [1:0] event_res
    input  logic                           i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    bpc_pkg::t_thresh thresh;
    logic             phase_idle;
    logic [1:0]       event_res;

    bpc_thresh u_thresh (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_phase_idle (phase_idle),
        .o_thresh     (thresh)
    );

    bpc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_thresh     (thresh),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_level      (s_axis_tdata[0]),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_event      (event_res),
        .o_phase_idle (phase_idle)
    );

    assign m_axis_tdata = {6'b0, event_res};

endmodule

// ----- src/bpc_thresh.sv -----
// Config registers and a two-lane radix-2 divider for the tick thresholds.
module bpc_thresh (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_phase_idle,
    output bpc_pkg::t_thresh                o_thresh
);

    logic [bpc_pkg::PERIOD_W-1:0] r_scan;
    logic                         r_al;
    logic [bpc_pkg::TICK_W-1:0]   r_gap_ms;
    logic [bpc_pkg::TICK_W-1:0]   r_long_ms;
    logic                         r_start;
    logic                         r_run;
    logic [3:0]                   r_cnt;
    logic [bpc_pkg::TICK_W-1:0]   r_long_ticks;
    logic [bpc_pkg::TICK_W-1:0]   r_gap_ticks;

    // divider datapath
    logic [bpc_pkg::PERIOD_W-1:0] r_div;
    logic [bpc_pkg::PERIOD_W-1:0] r_lrem, r_grem;
    logic [bpc_pkg::TICK_W-1:0]   r_lq, r_gq;
    logic [bpc_pkg::PERIOD_W-1:0] n_lrem, n_grem;
    logic [bpc_pkg::TICK_W-1:0]   n_lq, n_gq;
    logic [bpc_pkg::PERIOD_W:0]   l_trial, g_trial;
    logic                         l_ge, g_ge;

    // one quotient bit per lane per cycle
    always_comb begin
        l_trial = {r_lrem, r_lq[bpc_pkg::TICK_W-1]};
        g_trial = {r_grem, r_gq[bpc_pkg::TICK_W-1]};
        l_ge    = (l_trial >= {1'b0, r_div});
        g_ge    = (g_trial >= {1'b0, r_div});
        n_lrem  = l_ge ? bpc_pkg::PERIOD_W'(l_trial - {1'b0, r_div})
                       : bpc_pkg::PERIOD_W'(l_trial);
        n_grem  = g_ge ? bpc_pkg::PERIOD_W'(g_trial - {1'b0, r_div})
                       : bpc_pkg::PERIOD_W'(g_trial);
        n_lq    = {r_lq[bpc_pkg::TICK_W-2:0], l_ge};
        n_gq    = {r_gq[bpc_pkg::TICK_W-2:0], g_ge};
    end

    // config registers, divider control, thresholds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan       <= bpc_pkg::RST_SCAN_PERIOD;
            r_al         <= bpc_pkg::RST_ACTIVE_LVL;
            r_gap_ms     <= bpc_pkg::RST_DOUBLE_GAP;
            r_long_ms    <= bpc_pkg::RST_LONG_PRESS;
            r_start      <= 1'b0;
            r_run        <= 1'b0;
            r_cnt        <= '0;
            r_long_ticks <= bpc_pkg::RST_LONG_TICKS;
            r_gap_ticks  <= bpc_pkg::RST_GAP_TICKS;
        end else begin
            if (i_cfg_we) begin
                unique case (bpc_pkg::t_cfg_idx'(i_cfg_idx))
                    bpc_pkg::CFG_SCAN_PERIOD: r_scan    <= i_cfg_data[bpc_pkg::PERIOD_W-1:0];
                    bpc_pkg::CFG_ACTIVE_LVL:  r_al      <= i_cfg_data[0];
                    bpc_pkg::CFG_DOUBLE_GAP:  r_gap_ms  <= i_cfg_data;
                    bpc_pkg::CFG_LONG_PRESS:  r_long_ms <= i_cfg_data;
                    default: ;
                endcase
            end
            // thresholds follow a write only when no press is in progress
            r_start <= i_cfg_we && i_phase_idle;
            if (r_start) begin
                r_run <= 1'b1;
                r_cnt <= 4'd15;
            end else if (r_run) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_run        <= 1'b0;
                    r_long_ticks <= n_lq;
                    r_gap_ticks  <= n_gq;
                end
            end
        end
    end

    // divider operands
    always_ff @(posedge i_clk) begin
        if (r_start) begin
            r_div  <= (r_scan == '0) ? bpc_pkg::PERIOD_W'(1) : r_scan;
            r_lrem <= '0;
            r_grem <= '0;
            r_lq   <= r_long_ms;
            r_gq   <= r_gap_ms;
        end else if (r_run) begin
            r_lrem <= n_lrem;
            r_grem <= n_grem;
            r_lq   <= n_lq;
            r_gq   <= n_gq;
        end
    end

    assign o_thresh.busy         = r_start | r_run;
    assign o_thresh.active_level = r_al;
    assign o_thresh.long_ticks   = r_long_ticks;
    assign o_thresh.gap_ticks    = r_gap_ticks;

endmodule

// ----- src/bpc_core.sv -----
// Input register, press state update and output register.
module bpc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bpc_pkg::t_thresh i_thresh,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_level,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_event,
    output logic             o_phase_idle
);

    logic                       r_in_valid;
    logic                       r_in_level;
    logic                       r_out_valid;
    bpc_pkg::t_event            r_out_event;
    logic                       r_prev;
    bpc_pkg::t_phase            r_phase;
    logic [bpc_pkg::TICK_W-1:0] r_cnt;

    bpc_pkg::t_phase            n_phase;
    logic [bpc_pkg::TICK_W-1:0] n_cnt;
    bpc_pkg::t_event            n_event;
    logic [bpc_pkg::TICK_W-1:0] cnt_inc;
    logic [bpc_pkg::TICK_W-1:0] gap_cnt;
    logic                       pressed, prev_pressed;
    logic                       adv, take;

    // handshake: move when the result slot is free or being drained
    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !i_thresh.busy && (!r_in_valid || adv);
    assign take    = i_valid && o_ready;

    // per-tick classification
    always_comb begin
        pressed      = (r_in_level == i_thresh.active_level);
        prev_pressed = (r_prev == i_thresh.active_level);
        cnt_inc      = r_cnt + bpc_pkg::TICK_W'(1);
        gap_cnt      = pressed ? r_cnt : cnt_inc;
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_event      = bpc_pkg::EV_NONE;
        unique case (r_phase)
            bpc_pkg::PH_HELD: begin
                if (pressed && prev_pressed) begin
                    if (cnt_inc >= i_thresh.long_ticks) begin
                        n_event = bpc_pkg::EV_LONG;
                        n_phase = bpc_pkg::PH_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end else if (r_in_level != r_prev) begin
                    n_phase = bpc_pkg::PH_RELEASED;
                    n_cnt   = '0;
                end
            end
            bpc_pkg::PH_RELEASED: begin
                if (pressed && gap_cnt < i_thresh.gap_ticks) begin
                    n_event = bpc_pkg::EV_DOUBLE;
                    n_phase = bpc_pkg::PH_IDLE;
                    n_cnt   = '0;
                end else if (gap_cnt >= i_thresh.gap_ticks) begin
                    n_event = bpc_pkg::EV_SINGLE;
                    n_phase = bpc_pkg::PH_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = gap_cnt;
                end
            end
            // idle, and the unused code treated as idle
            default: begin
                n_phase = (pressed && !prev_pressed) ? bpc_pkg::PH_HELD : bpc_pkg::PH_IDLE;
            end
        endcase
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= 1'b0;
            r_phase     <= bpc_pkg::PH_IDLE;
            r_cnt       <= '0;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_prev      <= r_in_level;
                r_phase     <= n_phase;
                r_cnt       <= n_cnt;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_level <= i_level;
        end
        if (adv) begin
            r_out_event <= n_event;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_event      = r_out_event;
    assign o_phase_idle = (r_phase == bpc_pkg::PH_IDLE);

endmodule

// ----- src/bpc_checker.sv -----
`include "button_press_classifier_unit_assert.svh"

// Port-level checks on the classifier.
module bpc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [7:0]                     m_axis_tdata
);

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // stalled result word holds
    `BPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // a result word is pending after every accepted tick
    `BPC_ASSERT_NOW(a_in_to_out, s_acc, ##2 m_axis_tvalid)
    // padding bits of the result word stay zero
    `BPC_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[7:2] == 6'd0)
    // nothing is offered in the cycle after a reset cycle
    `BPC_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n, !m_axis_tvalid)

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (.*);

// ----- verif/button_press_classifier_unit_test.sv -----
module button_press_classifier_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bpc_pkg::*;

    localparam int unsigned RESET_CYCLES  = 5;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned PRINT_LIMIT   = 40;

    // DUT ports
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;  // [0] pin_level
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;        // [1:0] event_res
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // Idle control and bookkeeping
    bit          gaps_on   = 1'b0;
    bit          stalls_on = 1'b0;
    int unsigned stall_left;
    int unsigned ticks_sent;
    int unsigned error_count;
    int unsigned cycle_count;
    t_event      event_q[$];
    t_event      want_event;

    // Classifier state tracked alongside the DUT
    logic [PERIOD_W-1:0] period_ms;
    logic                active_lvl;
    logic [TICK_W-1:0]   gap_ms;
    logic [TICK_W-1:0]   long_ms;
    logic                prev_lvl;
    t_phase              press_phase;
    logic [TICK_W-1:0]   phase_ticks;
    logic [TICK_W-1:0]   long_thr;
    logic [TICK_W-1:0]   gap_thr;

    button_press_classifier_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Threshold division; a zero period divides as one
    function automatic void recompute_thresholds();
        logic [TICK_W-1:0] div;
        div = (period_ms == '0) ? TICK_W'(1) : TICK_W'(period_ms);
        long_thr = long_ms / div;
        gap_thr  = gap_ms / div;
    endfunction

    function automatic void reset_classifier();
        period_ms   = RST_SCAN_PERIOD;
        active_lvl  = RST_ACTIVE_LVL;
        gap_ms      = RST_DOUBLE_GAP;
        long_ms     = RST_LONG_PRESS;
        prev_lvl    = 1'b0;
        press_phase = PH_IDLE;
        phase_ticks = '0;
        recompute_thresholds();
    endfunction

    // Register write; thresholds only follow while no press is tracked
    function automatic void apply_setting(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SCAN_PERIOD: period_ms  = data[PERIOD_W-1:0];
            CFG_ACTIVE_LVL:  active_lvl = data[0];
            CFG_DOUBLE_GAP:  gap_ms     = data;
            CFG_LONG_PRESS:  long_ms    = data;
        endcase
        if (press_phase == PH_IDLE)
            recompute_thresholds();
    endfunction

    // One scan tick through the press classifier
    function automatic t_event classify_tick(logic lvl);
        logic   now_on;
        logic   was_on;
        t_event ev;
        now_on = (lvl == active_lvl);
        was_on = (prev_lvl == active_lvl);
        ev     = EV_NONE;
        case (press_phase)
            PH_HELD: begin
                if (now_on && was_on) begin
                    phase_ticks = phase_ticks + 1'b1;
                    if (phase_ticks >= long_thr) begin
                        ev          = EV_LONG;
                        press_phase = PH_IDLE;
                        phase_ticks = '0;
                    end
                end else if (lvl != prev_lvl) begin
                    press_phase = PH_RELEASED;
                    phase_ticks = '0;
                end
            end
            PH_RELEASED: begin
                if (!now_on)
                    phase_ticks = phase_ticks + 1'b1;
                if (phase_ticks < gap_thr && now_on) begin
                    ev          = EV_DOUBLE;
                    press_phase = PH_IDLE;
                    phase_ticks = '0;
                end else if (phase_ticks >= gap_thr) begin
                    ev          = EV_SINGLE;
                    press_phase = PH_IDLE;
                    phase_ticks = '0;
                end
            end
            default: begin
                if (now_on && !was_on)
                    press_phase = PH_HELD;
            end
        endcase
        prev_lvl = lvl;
        return ev;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Track accepted tick words and config writes
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_we)
            apply_setting(t_cfg_idx'(i_cfg_idx), i_cfg_data);
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            event_q.push_back(classify_tick(s_axis_tdata[0]));
    end

    // Compare each event word with the oldest pending event
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (event_q.size() == 0) begin
                report_mismatch($sformatf("event word 0x%02h with nothing pending",
                                          m_axis_tdata));
            end else begin
                want_event = event_q.pop_front();
                if (m_axis_tdata[1:0] !== want_event)
                    report_mismatch($sformatf("event_res %0d, want %0d (%s)",
                                              m_axis_tdata[1:0], want_event,
                                              want_event.name()));
                if (m_axis_tdata[7:2] !== '0)
                    report_mismatch($sformatf("fill bits 0x%02h not zero", m_axis_tdata));
            end
        end
    end

    // Receiver stalls at random while stalls_on is set
    always @(posedge i_clk) begin
        if (!stalls_on) begin
            stall_left    <= 0;
            m_axis_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left    <= $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Send one tick word, with an optional idle burst first
    task automatic send_tick(input logic lvl);
        int unsigned gap;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, lvl};
        do @(posedge i_clk); while (!s_axis_tready);
        ticks_sent++;
    endtask

    // Wait until every event word is back and the pipeline has settled
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (event_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Config write, then wait out the threshold divider
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        repeat (3) @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_run(input logic lvl, input int unsigned n);
        repeat (n) send_tick(lvl);
    endtask

    // Well-formed press and release with random lengths around the thresholds,
    // now and then a few noise ticks instead
    task automatic send_press_pattern();
        int unsigned hold_cap;
        int unsigned gap_cap;
        int unsigned k;
        logic        on;
        hold_cap = (long_thr > 24) ? 26 : long_thr + 2;
        gap_cap  = (gap_thr > 24) ? 26 : gap_thr + 2;
        on       = active_lvl;
        k        = $urandom_range(0, 9);
        if (k == 0) begin
            repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
        end else begin
            if (k > 2)
                send_tick(~on);
            send_run(on, $urandom_range(1, hold_cap));
            send_run(~on, $urandom_range(1, gap_cap));
        end
    endtask

    // Random but reachable thresholds: a few ticks at any period
    task automatic write_random_config(input bit all_regs);
        logic [PERIOD_W-1:0] per;
        logic [15:0]         junk;
        int unsigned         div;
        junk = 16'($urandom);
        per  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(1, 20));
        div  = (per == 0) ? 1 : per;
        if (all_regs || $urandom_range(0, 3) != 0)
            write_reg(CFG_SCAN_PERIOD, {junk[15:8], per});
        if (all_regs || $urandom_range(0, 3) != 0)
            write_reg(CFG_ACTIVE_LVL, {junk[15:1], 1'($urandom_range(0, 1))});
        if (all_regs || $urandom_range(0, 3) != 0)
            write_reg(CFG_DOUBLE_GAP,
                      16'($urandom_range(0, 10) * div + $urandom_range(0, div - 1)));
        if (all_regs || $urandom_range(0, 3) != 0)
            write_reg(CFG_LONG_PRESS,
                      16'($urandom_range(0, 15) * div + $urandom_range(0, div - 1)));
    endtask

    // Reset thresholds, active low: press, release, quick press is a double
    task automatic test_reset_thresholds();
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        drain();
    endtask

    // Active high, period 4: gap 9 ms -> 2 ticks, long 14 ms -> 3 ticks
    task automatic test_press_kinds();
        write_reg(CFG_ACTIVE_LVL, 16'd1);
        write_reg(CFG_SCAN_PERIOD, 16'd4);
        write_reg(CFG_DOUBLE_GAP, 16'd9);
        write_reg(CFG_LONG_PRESS, 16'd14);
        // single: release outlasts the gap
        send_tick(1'b0);
        send_tick(1'b1);
        send_run(1'b0, 3);
        // double: new press inside the gap
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        // long: hold three more ticks after the press
        send_tick(1'b0);
        send_run(1'b1, 4);
        drain();
    endtask

    // Period 0 (upper data bits set) divides as one; both thresholds zero
    task automatic test_zero_thresholds();
        write_reg(CFG_SCAN_PERIOD, 16'hAB00);
        write_reg(CFG_DOUBLE_GAP, 16'd0);
        write_reg(CFG_LONG_PRESS, 16'd0);
        // long on the first held tick
        send_tick(1'b0);
        send_run(1'b1, 2);
        // single on the first released tick, inactive level
        send_tick(1'b0);
        send_tick(1'b1);
        send_run(1'b0, 2);
        // single on the first released tick, even when pressed again
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        drain();
    endtask

    // Active level flipped while held: phase kept, thresholds frozen
    task automatic test_level_change_mid_press();
        write_reg(CFG_SCAN_PERIOD, 16'd1);
        write_reg(CFG_DOUBLE_GAP, 16'd3);
        write_reg(CFG_LONG_PRESS, 16'd10);
        send_tick(1'b0);
        send_tick(1'b1);
        drain();
        write_reg(CFG_ACTIVE_LVL, 16'd0);
        write_reg(CFG_LONG_PRESS, 16'd1);
        // inactive and steady: held phase just waits
        send_run(1'b1, 2);
        // level change releases; pressed right away gives a double
        send_run(1'b0, 2);
        drain();
    endtask

    // Largest period with largest times: both thresholds 257 ticks
    task automatic test_threshold_extremes();
        write_reg(CFG_SCAN_PERIOD, 16'd1);
        write_reg(CFG_LONG_PRESS, 16'hFFFF);
        write_reg(CFG_ACTIVE_LVL, 16'd0);
        write_reg(CFG_SCAN_PERIOD, 16'd255);
        write_reg(CFG_DOUBLE_GAP, 16'hFFFF);
        write_reg(CFG_LONG_PRESS, 16'hFFFF);
        send_tick(1'b1);
        send_run(1'b0, 258);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_run(1'b1, 260);
        drain();
    endtask

    // Phases of random settings and press patterns, idling per phase
    task automatic test_random_presses();
        int unsigned phase_end;
        repeat (6) begin
            drain();
            write_random_config(1'b0);
            gaps_on   = ($urandom_range(0, 4) != 0);
            stalls_on = ($urandom_range(0, 4) != 0);
            phase_end = ticks_sent + 130;
            while (ticks_sent < phase_end) send_press_pattern();
        end
    endtask

    // Last stretch: no idling on either side
    task automatic test_back_to_back();
        int unsigned phase_end;
        drain();
        write_random_config(1'b1);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        phase_end = ticks_sent + 200;
        while (ticks_sent < phase_end) send_press_pattern();
    endtask

    initial begin
        error_count = 0;
        ticks_sent  = 0;
        stall_left  = 0;
        reset_classifier();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;

        test_reset_thresholds();
        test_press_kinds();
        test_zero_thresholds();
        test_level_change_mid_press();
        test_threshold_extremes();
        test_random_presses();
        test_back_to_back();
        drain();

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/bpc_pkg.sv
src/bpc_thresh.sv
src/bpc_core.sv
src/button_press_classifier_unit.sv
src/bpc_checker.sv
verif/button_press_classifier_unit_test.sv
